// File: design/lfhc_pkg.sv
// Shared types, codes and helper functions for the LIN frame header and checksum checker.
`default_nettype none

package lfhc_pkg;

	// Largest number of response data bytes in one frame.
	localparam int unsigned MAX_DATA_BYTES = 8;

	// Byte role codes reported with each word.
	localparam logic [2:0] ROLE_SYNC    = 3'd0;
	localparam logic [2:0] ROLE_ID      = 3'd1;
	localparam logic [2:0] ROLE_DATA    = 3'd2;
	localparam logic [2:0] ROLE_CSUM    = 3'd3;
	localparam logic [2:0] ROLE_IGNORED = 3'd4;

	localparam logic [7:0] SYNC_PATTERN = 8'h55;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_PID  = 4'b0010,
		PH_DATA = 4'b0100,
		PH_CSUM = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       checksum_mode;
		logic [3:0] data_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0] byte_role;
		logic [5:0] frame_id;
		logic       header_valid;
		logic [7:0] expected_checksum;
		logic       checksum_ok;
		logic       frame_end;
	} result_t;

	// Protected identifier: ID in bits 5:0, P0 in bit 6, inverted P1 in bit 7.
	function automatic logic [7:0] make_pid(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Two end-around carry folds of the 12-bit sum, then inversion.
	function automatic logic [7:0] fold_invert(input logic [11:0] sum);
		logic [8:0] s1;
		logic [8:0] s2;
		s1 = {1'b0, sum[7:0]} + {5'b0, sum[11:8]};
		s2 = {1'b0, s1[7:0]} + {8'b0, s1[8]};
		return ~s2[7:0];
	endfunction

endpackage

`default_nettype wire

// File: design/lfhc_cfg_regs.sv
// APB-style configuration registers: checksum mode and data length.
`default_nettype none

module lfhc_cfg_regs
	import lfhc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	localparam logic REG_CHECKSUM_MODE = 1'b0;
	localparam logic REG_DATA_LENGTH   = 1'b1;

	logic       checksum_mode_q;
	logic [3:0] data_length_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_mode_q <= 1'b1;
			data_length_q   <= 4'd8;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CHECKSUM_MODE: checksum_mode_q <= pwdata[0];
				REG_DATA_LENGTH:   data_length_q   <= pwdata[3:0];
				default:           checksum_mode_q <= checksum_mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CHECKSUM_MODE: prdata = {31'b0, checksum_mode_q};
			REG_DATA_LENGTH:   prdata = {28'b0, data_length_q};
			default:           prdata = 32'b0;
		endcase
	end

	assign cfg.checksum_mode = checksum_mode_q;
	assign cfg.data_length   = data_length_q;

endmodule

`default_nettype wire

// File: design/lfhc_frame_engine.sv
// Frame tracking state and per-word result logic for LIN header and checksum checks.
`default_nettype none

module lfhc_frame_engine
	import lfhc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic       after_break,
	input  wire cfg_t       cfg,
	output result_t         res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  data_count_q, data_count_d;
	logic [11:0] running_sum_q, running_sum_d;
	logic        sync_matched_q, sync_matched_d;
	logic [5:0]  held_id_q, held_id_d;
	logic [3:0]  eff_len;
	logic [3:0]  count_inc;

	// Out-of-range lengths are clamped into 1..MAX_DATA_BYTES.
	always_comb begin
		if (cfg.data_length == 4'd0) begin
			eff_len = 4'd1;
		end else if (cfg.data_length > 4'(MAX_DATA_BYTES)) begin
			eff_len = 4'(MAX_DATA_BYTES);
		end else begin
			eff_len = cfg.data_length;
		end
	end

	assign count_inc = data_count_q + 4'd1;

	always_comb begin
		phase_d        = phase_q;
		data_count_d   = data_count_q;
		running_sum_d  = running_sum_q;
		sync_matched_d = sync_matched_q;
		held_id_d      = held_id_q;
		res.byte_role    = ROLE_IGNORED;
		res.header_valid = 1'b0;
		res.checksum_ok  = 1'b0;
		res.frame_end    = 1'b0;

		if (after_break) begin
			// A break always restarts framing, whatever was in progress.
			res.byte_role  = ROLE_SYNC;
			sync_matched_d = (rx_byte == SYNC_PATTERN);
			data_count_d   = 4'd0;
			running_sum_d  = 12'd0;
			phase_d        = PH_PID;
		end else begin
			unique case (phase_q)
				PH_PID: begin
					res.byte_role    = ROLE_ID;
					held_id_d        = rx_byte[5:0];
					res.header_valid = sync_matched_q && (make_pid(rx_byte[5:0]) == rx_byte);
					data_count_d     = 4'd0;
					running_sum_d    = cfg.checksum_mode ? {4'b0, rx_byte} : 12'd0;
					phase_d          = res.header_valid ? PH_DATA : PH_IDLE;
				end
				PH_DATA: begin
					res.byte_role = ROLE_DATA;
					running_sum_d = running_sum_q + {4'b0, rx_byte};
					data_count_d  = count_inc;
					if (count_inc >= eff_len) begin
						phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					res.byte_role   = ROLE_CSUM;
					res.checksum_ok = (fold_invert(running_sum_q) == rx_byte);
					res.frame_end   = 1'b1;
					phase_d         = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		res.frame_id          = held_id_d;
		res.expected_checksum = fold_invert(running_sum_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			data_count_q   <= 4'd0;
			running_sum_q  <= 12'd0;
			sync_matched_q <= 1'b0;
			held_id_q      <= 6'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			data_count_q   <= data_count_d;
			running_sum_q  <= running_sum_d;
			sync_matched_q <= sync_matched_d;
			held_id_q      <= held_id_d;
		end
	end

	a_end_is_csum: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.frame_end |-> res.byte_role == ROLE_CSUM)
		else $error("frame end flagged on a word that is not a checksum");

	a_bad_header_idles: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.byte_role == ROLE_ID && !res.header_valid |=> phase_q == PH_IDLE)
		else $error("invalid header did not return the frame tracker to idle");

	a_break_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && after_break |=> phase_q == PH_PID && running_sum_q == 12'd0
			&& data_count_q == 4'd0)
		else $error("break did not restart the frame");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		data_count_q <= 4'(MAX_DATA_BYTES))
		else $error("data byte count ran past the frame maximum");

endmodule

`default_nettype wire

// File: design/lin_frame_header_and_checksum_checker_core.sv
// Top level of the LIN frame header and checksum checker with its result register.
`default_nettype none

// This block checks received LIN bytes, one word per cycle. A word flagged as
// following a break is taken as the sync byte and compared with 0x55; the next
// word is the protected identifier, whose two parity bits are recomputed from
// its low six bits. When the sync matched and the parity agrees the header is
// valid, and the block then sums data_length data bytes (plus the identifier
// in enhanced mode), folds the carries end-around, inverts the result and
// compares it with the checksum byte. After an invalid header, or outside a
// frame, words are reported as ignored until the next break. Each accepted
// word yields exactly one result word, in the next cycle, from a single result
// register; the frame state and the result are computed in one short step, so
// a new word is taken every cycle as long as the result register is empty or
// being drained in that same cycle. Configuration is written over the APB
// port at byte address 0 (checksum_mode, reset 1) and 4 (data_length, reset 8)
// and should only change while no frame is in flight; the checksum mode is
// sampled on the identifier byte and the length on each data byte.

module lin_frame_header_and_checksum_checker_core
	import lfhc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// incoming words
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        after_break,
	// result words
	output logic             result_valid,
	input  wire logic        out_ready,
	output logic [2:0]       byte_role,
	output logic [5:0]       frame_id,
	output logic             header_valid,
	output logic [7:0]       expected_checksum,
	output logic             checksum_ok,
	output logic             frame_end
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    result_valid_q;
	logic    accept;

	lfhc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register is free when empty or when its word leaves this cycle.
	assign in_ready = !result_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	lfhc_frame_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.after_break (after_break),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (in_ready) begin
			result_valid_q <= in_valid;
		end
	end

	// The payload carries no reset; it is only looked at while result_valid is high.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign result_valid      = result_valid_q;
	assign byte_role         = res_q.byte_role;
	assign frame_id          = res_q.frame_id;
	assign header_valid      = res_q.header_valid;
	assign expected_checksum = res_q.expected_checksum;
	assign checksum_ok       = res_q.checksum_ok;
	assign frame_end         = res_q.frame_end;

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the LIN frame header and checksum checker core.
`timescale 1ns / 100ps

module tb;
	import lfhc_pkg::*;

	// Byte addresses of the two configuration registers.
	localparam logic [2:0] ADDR_CHECKSUM_MODE = 3'd0;
	localparam logic [2:0] ADDR_DATA_LENGTH   = 3'd4;

	// Checksum modes as written to the mode register.
	localparam logic MODE_CLASSIC  = 1'b0;
	localparam logic MODE_ENHANCED = 1'b1;

	// Generous ceiling on the run length in clock cycles.
	localparam int CYCLE_LIMIT = 600000;

	// Number of counted words after which the random traffic stops.
	localparam int RANDOM_WORDS = 2000;

	// Clock, reset and every block input start at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        after_break = 1'b0;
	logic        result_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  byte_role;
	logic [5:0]  frame_id;
	logic        header_valid;
	logic [7:0]  expected_checksum;
	logic        checksum_ok;
	logic        frame_end;

	lin_frame_header_and_checksum_checker_core DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.after_break       (after_break),
		.result_valid      (result_valid),
		.out_ready         (out_ready),
		.byte_role         (byte_role),
		.frame_id          (frame_id),
		.header_valid      (header_valid),
		.expected_checksum (expected_checksum),
		.checksum_ok       (checksum_ok),
		.frame_end         (frame_end)
	);

	// The clock runs with a 10 ns period from time zero.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the configuration registers, updated at the write edge.
	logic       cfg_mode = MODE_ENHANCED;
	logic [3:0] cfg_len = 4'd8;

	// Our own copy of the frame tracking state, at its reset values.
	phase_t      lin_phase = PH_IDLE;
	logic [3:0]  data_seen = 4'd0;
	logic [11:0] byte_sum = 12'd0;
	logic        sync_was_good = 1'b0;
	logic [5:0]  held_frame_id = 6'd0;

	// Results predicted for accepted words, oldest first.
	result_t expected_results [$];

	// Bookkeeping shared by the test tasks and the result checker.
	int  mismatches = 0;
	int  cycle_count = 0;
	int  results_seen = 0;
	int  counted_words = 0;
	int  frames_closed = 0;
	int  checksums_matched = 0;
	int  headers_ok = 0;
	int  ignored_words = 0;
	int  config_writes = 0;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;
	bit  hold_request = 1'b0;

	// Data bytes of the next frame, filled before each frame is sent.
	logic [7:0] frame_bytes [0:MAX_DATA_BYTES-1];

	// The protected identifier carries P0 in bit 6 and the inverted P1 in bit 7.
	function automatic logic [7:0] pid_of(input logic [5:0] id);
		return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
	endfunction

	// Fold the carries of the 12-bit sum back in twice, then invert.
	function automatic logic [7:0] inv_folded_sum(input logic [11:0] total);
		logic [8:0] once;
		logic [8:0] twice;
		once = total[7:0] + total[11:8];
		twice = once[7:0] + once[8];
		return ~twice[7:0];
	endfunction

	// A length of zero acts as one and anything above the maximum is clamped.
	function automatic int eff_len();
		int n;
		n = cfg_len;
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_DATA_BYTES) begin
			n = MAX_DATA_BYTES;
		end
		return n;
	endfunction

	// Advance our copy of the frame state by one word and return the result
	// word that the block must produce for it.
	function automatic result_t predict_lin_result(input logic [7:0] value, input logic brk);
		result_t r;
		r.byte_role = ROLE_IGNORED;
		r.header_valid = 1'b0;
		r.checksum_ok = 1'b0;
		r.frame_end = 1'b0;
		if (brk) begin
			// A break always starts a new frame, whatever was in progress.
			r.byte_role = ROLE_SYNC;
			sync_was_good = (value == SYNC_PATTERN);
			data_seen = 4'd0;
			byte_sum = 12'd0;
			lin_phase = PH_PID;
		end else begin
			case (lin_phase)
				PH_PID: begin
					r.byte_role = ROLE_ID;
					held_frame_id = value[5:0];
					r.header_valid = sync_was_good && (pid_of(value[5:0]) == value);
					data_seen = 4'd0;
					// The mode is sampled here, on the identifier.
					byte_sum = (cfg_mode == MODE_ENHANCED) ? {4'd0, value} : 12'd0;
					lin_phase = r.header_valid ? PH_DATA : PH_IDLE;
				end
				PH_DATA: begin
					r.byte_role = ROLE_DATA;
					byte_sum = byte_sum + value;
					data_seen = data_seen + 4'd1;
					if (data_seen >= eff_len()) begin
						lin_phase = PH_CSUM;
					end
				end
				PH_CSUM: begin
					r.byte_role = ROLE_CSUM;
					r.checksum_ok = (inv_folded_sum(byte_sum) == value);
					r.frame_end = 1'b1;
					lin_phase = PH_IDLE;
				end
				default: begin
					lin_phase = PH_IDLE;
				end
			endcase
		end
		r.frame_id = held_frame_id;
		r.expected_checksum = inv_folded_sum(byte_sum);
		return r;
	endfunction

	// Every word the block accepts gets its predicted result queued here.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(predict_lin_result(rx_byte, after_break));
		end
	end

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Each result word leaving the block is compared with the oldest
	// prediction, one field at a time.
	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && result_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected, actual role %0d",
					$time, byte_role);
			end else begin
				want = expected_results.pop_front();
				check_field("byte_role", want.byte_role, byte_role);
				check_field("frame_id", want.frame_id, frame_id);
				check_field("header_valid", want.header_valid, header_valid);
				check_field("expected_checksum", want.expected_checksum, expected_checksum);
				check_field("checksum_ok", want.checksum_ok, checksum_ok);
				check_field("frame_end", want.frame_end, frame_end);
				if (want.byte_role == ROLE_IGNORED) begin
					ignored_words++;
				end else begin
					counted_words++;
				end
				frames_closed += want.frame_end;
				checksums_matched += want.checksum_ok;
				headers_ok += want.header_valid;
			end
		end
	end

	// A hung handshake must not keep the run going forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding",
				$time, expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// The receiver draws a stall before each result word. When a long hold
	// is requested it instead stops taking results for a long stretch, so
	// the result register fills and the block has to refuse new words.
	initial begin : receiver_pace
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = $urandom_range(40, 80);
			end else if (stalls_on) begin
				stall = $urandom_range(0, 18);
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Offer one word after a drawn gap and hold it until the block takes it.
	// Valid is left high on return so that back-to-back words need no gap.
	task automatic send_byte(input logic [7:0] value, input logic brk);
		int gap;
		gap = gaps_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		after_break <= brk;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every predicted result has come out, then
	// let the clock run on so that the block is surely idle.
	task automatic drain_pending();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// A register write is a setup cycle followed by an access cycle; the
	// register takes the value at the end of the access cycle.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_CHECKSUM_MODE) begin
			cfg_mode = value[0];
		end else begin
			cfg_len = value[3:0];
		end
		config_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			mismatches++;
			$display("%0t: register at address %0d read mismatch, expected %0h, actual %0h",
				$time, addr, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Registers only change while the block is idle, and are read back after.
	task automatic set_config(input logic mode, input logic [3:0] len);
		drain_pending();
		apb_write(ADDR_CHECKSUM_MODE, {31'd0, mode});
		apb_write(ADDR_DATA_LENGTH, {28'd0, len});
		apb_read_check(ADDR_CHECKSUM_MODE, {31'd0, mode});
		apb_read_check(ADDR_DATA_LENGTH, {28'd0, len});
	endtask

	// Random payload with a bias toward the all-zero and all-one bytes, so
	// that the sum both stays at zero and carries over repeatedly.
	task automatic fill_frame_data();
		for (int i = 0; i < MAX_DATA_BYTES; i++) begin
			case ($urandom_range(0, 7))
				0: frame_bytes[i] = 8'h00;
				1: frame_bytes[i] = 8'hFF;
				default: frame_bytes[i] = 8'($urandom_range(0, 255));
			endcase
		end
	endtask

	// Send a break-flagged sync, an identifier and n_data data bytes. The
	// checksum byte follows only when the data part is complete, so a short
	// n_data leaves the frame open for whatever comes next.
	task automatic send_frame(input logic [7:0] sync_b, input logic [7:0] pid_b,
			input int n_data, input bit csum_good);
		logic [11:0] total;
		logic [7:0]  ck;
		logic [7:0]  corrupt;
		total = (cfg_mode == MODE_ENHANCED) ? {4'd0, pid_b} : 12'd0;
		corrupt = 8'($urandom_range(1, 255));
		send_byte(sync_b, 1'b1);
		send_byte(pid_b, 1'b0);
		for (int i = 0; i < n_data; i++) begin
			send_byte(frame_bytes[i], 1'b0);
			total = total + frame_bytes[i];
		end
		if (n_data == eff_len()) begin
			ck = inv_folded_sum(total);
			if (!csum_good) begin
				ck = ck ^ corrupt;
			end
			send_byte(ck, 1'b0);
		end
	endtask

	// The registers come out of reset in enhanced mode with eight data bytes.
	task automatic test_reset_values();
		apb_read_check(ADDR_CHECKSUM_MODE, 32'd1);
		apb_read_check(ADDR_DATA_LENGTH, 32'd8);
	endtask

	// A short hand-picked sequence: stray bytes before any break, a bad sync,
	// each parity bit wrong, all-ones and all-zero frames with good and bad
	// checksums, and a frame cut short by a new break.
	task automatic test_directed_frames();
		set_config(MODE_ENHANCED, 4'd2);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		frame_bytes[0] = 8'hAA;
		send_frame(8'hFF, pid_of(6'h3F), 1, 1'b1);
		send_frame(SYNC_PATTERN, pid_of(6'h05) ^ 8'h40, 1, 1'b1);
		send_frame(SYNC_PATTERN, pid_of(6'h05) ^ 8'h80, 0, 1'b1);
		frame_bytes[0] = 8'hFF;
		frame_bytes[1] = 8'hFF;
		send_frame(SYNC_PATTERN, pid_of(6'h3F), 2, 1'b1);
		frame_bytes[0] = 8'h00;
		frame_bytes[1] = 8'h00;
		send_frame(SYNC_PATTERN, pid_of(6'h00), 2, 1'b0);
		frame_bytes[0] = 8'h5A;
		send_frame(SYNC_PATTERN, pid_of(6'h2A), 1, 1'b1);
		frame_bytes[0] = 8'h80;
		frame_bytes[1] = 8'h7F;
		send_frame(SYNC_PATTERN, pid_of(6'h15), 2, 1'b1);
	endtask

	// Walk through both modes at the shortest and longest lengths, including
	// the out-of-range length codes, with a few frames at each setting.
	task automatic test_config_sweep();
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: set_config(MODE_CLASSIC, 4'd1);
				1: set_config(MODE_ENHANCED, 4'd1);
				2: set_config(MODE_CLASSIC, 4'd8);
				3: set_config(MODE_ENHANCED, 4'd0);
				4: set_config(MODE_CLASSIC, 4'd15);
				default: set_config(MODE_ENHANCED, 4'd9);
			endcase
			for (int f = 0; f < 3; f++) begin
				fill_frame_data();
				send_frame(SYNC_PATTERN, pid_of(6'($urandom_range(0, 63))), eff_len(),
					f != 1);
			end
		end
	endtask

	// The receiver stops for a long stretch while the sender keeps words
	// coming with no gaps; then the sender waits for every result.
	task automatic test_backpressure();
		set_config(MODE_ENHANCED, 4'd8);
		gaps_on = 1'b0;
		hold_request = 1'b1;
		for (int f = 0; f < 3; f++) begin
			fill_frame_data();
			send_frame(SYNC_PATTERN, pid_of(6'($urandom_range(0, 63))), eff_len(), 1'b1);
		end
		drain_pending();
		gaps_on = 1'b1;
	endtask

	// Mostly complete frames with random content, mixed with broken headers,
	// truncated frames and stray noise. The settings change every few dozen
	// frames, and the idling on both sides is switched on and off per frame.
	task automatic test_random_traffic();
		int          kind;
		int          frames_left;
		logic [3:0]  len_pick;
		logic [7:0]  sync_b;
		logic [7:0]  pid_b;
		logic [1:0]  parity_flip;
		frames_left = 0;
		while (counted_words < RANDOM_WORDS) begin
			if (frames_left == 0) begin
				if ($urandom_range(0, 5) == 0) begin
					len_pick = 4'($urandom_range(0, 15));
				end else begin
					len_pick = 4'($urandom_range(1, 8));
				end
				set_config(1'($urandom_range(0, 1)), len_pick);
				frames_left = $urandom_range(10, 40);
			end
			frames_left--;
			gaps_on = ($urandom_range(0, 4) != 0);
			stalls_on = ($urandom_range(0, 4) != 0);
			fill_frame_data();
			kind = $urandom_range(0, 9);
			pid_b = pid_of(6'($urandom_range(0, 63)));
			if (kind <= 5) begin
				send_frame(SYNC_PATTERN, pid_b, eff_len(), $urandom_range(0, 3) != 0);
			end else if (kind == 6) begin
				// Either the sync is off or one or both parity bits are wrong.
				sync_b = SYNC_PATTERN;
				if ($urandom_range(0, 1) == 1) begin
					sync_b = sync_b ^ 8'($urandom_range(1, 255));
				end else begin
					parity_flip = 2'($urandom_range(1, 3));
					pid_b = pid_b ^ {parity_flip, 6'd0};
				end
				send_frame(sync_b, pid_b, $urandom_range(0, eff_len()), 1'b1);
			end else if (kind == 7) begin
				send_frame(SYNC_PATTERN, pid_b, $urandom_range(0, eff_len() - 1), 1'b1);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end
			end
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Reset is held low from time zero and then released, then the tests run in turn.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_frames();
		test_config_sweep();
		test_backpressure();
		test_random_traffic();
		drain_pending();
		repeat (4) @(posedge clk);
		$display("Checked %0d result words: %0d frames closed, %0d with a matching checksum,",
			results_seen, frames_closed, checksums_matched);
		$display("%0d valid headers, %0d ignored words, %0d register writes.",
			headers_ok, ignored_words, config_writes);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
